### rtl/core/mh64_pkg.sv
// Shared types, constants and helpers for the MurmurHash64A unit.
// Used by every module in rtl/core; depends on nothing else.
package mh64_pkg;

  localparam logic [63:0] MUL_CONST  = 64'hc6a4a7935bd1e995;
  localparam int unsigned SHIFT_BITS = 47;
  localparam logic [63:0] SEED_RESET = 64'h000000decafcaffe;
  localparam logic [7:0]  BYTE_MASK  = 8'hff;
  localparam int unsigned WORD_BYTES = 8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BLOCK,
    OP_PARTIAL
  } op_t;

  typedef struct packed {
    logic [63:0] data;
    logic [31:0] length;
    op_t         op;
    logic        first;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DISPATCH,
    ST_K1,
    ST_K2,
    ST_H,
    ST_FINAL,
    ST_FIN
  } state_t;

  function automatic logic [63:0] shift_mix(input logic [63:0] x);
    shift_mix = x ^ (x >> SHIFT_BITS);
  endfunction

endpackage

### rtl/core/mh64_front.sv
// Front end: classifies an incoming word and masks the bytes of a partial word.
// Depends on mh64_pkg for the command type and constants.
module mh64_front (
  input  logic               in_push,
  input  logic               q_full,
  input  logic [63:0]        data_word,
  input  logic [3:0]         word_bytes,
  input  logic               first_word,
  input  logic               last_word,
  input  logic [31:0]        message_length,
  output logic               q_push,
  output mh64_pkg::cmd_t     q_cmd
);

  logic [63:0] mask;
  logic        full_block;

  always_comb begin
    for (int i = 0; i < mh64_pkg::WORD_BYTES; i++) begin
      mask[8*i +: 8] = (4'(i) < word_bytes) ? mh64_pkg::BYTE_MASK : 8'h00;
    end
  end

  assign full_block = !last_word || (word_bytes >= 4'(mh64_pkg::WORD_BYTES));

  always_comb begin
    q_cmd.length = message_length;
    q_cmd.first  = first_word;
    q_cmd.last   = last_word;
    if (full_block) begin
      q_cmd.op   = mh64_pkg::OP_BLOCK;
      q_cmd.data = data_word;
    end else if (word_bytes != 4'd0) begin
      q_cmd.op   = mh64_pkg::OP_PARTIAL;
      q_cmd.data = data_word & mask;
    end else begin
      q_cmd.op   = mh64_pkg::OP_NONE;
      q_cmd.data = data_word;
    end
  end

  assign q_push = in_push && !q_full;

endmodule

### rtl/core/mh64_cmd_queue.sv
// Short command queue between the front end and the hash sequencer.
// Depends on mh64_pkg for the command type and the queue depth.
module mh64_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mh64_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output mh64_pkg::cmd_t     head_cmd,
  output logic               full,
  output logic               empty
);

  mh64_pkg::cmd_t                       entry_r [mh64_pkg::QUEUE_DEPTH];
  logic [mh64_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [mh64_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [mh64_pkg::QCNT_W-1:0]          count_r, count_nxt;
  logic                                 do_push, do_pop;

  assign full     = (count_r == mh64_pkg::QCNT_W'(mh64_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mh64_pkg::QPTR_W'(mh64_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mh64_pkg::QPTR_W'(mh64_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mh64_pkg::QCNT_W'(mh64_pkg::QUEUE_DEPTH))
    else $error("command queue count exceeds its depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("command queue count missed a push");
`endif

endmodule

### rtl/core/mh64_mul.sv
// Low 64 bits of a 64-bit operand times the hash constant, built from one
// shared 32x32 multiplier in three partial-product steps. Depends on mh64_pkg.
module mh64_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           operand,
  output logic [63:0]           product,
  output mh64_pkg::mul_stat_t   stat
);

  logic [63:0] a_r;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  step_r;
  logic        busy_r, done_r;
  logic [31:0] mx, my;
  logic [63:0] pp;

  always_comb begin
    case (step_r)
      2'd0: begin
        mx = a_r[31:0];
        my = mh64_pkg::MUL_CONST[31:0];
      end
      2'd1: begin
        mx = a_r[63:32];
        my = mh64_pkg::MUL_CONST[31:0];
      end
      2'd2: begin
        mx = a_r[31:0];
        my = mh64_pkg::MUL_CONST[63:32];
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
    pp = {32'd0, mx} * {32'd0, my};
    if (step_r == 2'd0) begin
      acc_nxt = pp;
    end else begin
      acc_nxt = {acc_r[63:32] + pp[31:0], acc_r[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r <= operand;
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && $past(step_r) == 2'd2))
    else $error("multiplier finished without three partial products");
`endif

endmodule

### rtl/core/mh64_back.sv
// Hash sequencer: runs seeding, block mixing, tail mixing and finalization
// on the shared multiplier and holds the result register. Depends on
// mh64_pkg and mh64_mul.
module mh64_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [63:0]        cfg_wr_data,
  input  mh64_pkg::cmd_t     q_cmd,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [63:0]        out_hash_value
);

  mh64_pkg::state_t     state_r, state_nxt;
  mh64_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [63:0]          seed_r;
  logic [63:0]          h_r, h_nxt;
  logic [63:0]          res_r, res_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_load, slot_free;
  logic                 mul_start;
  logic [63:0]          mul_a;
  logic [63:0]          mul_p;
  mh64_pkg::mul_stat_t  mul_stat;

  mh64_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_a),
    .product (mul_p),
    .stat    (mul_stat)
  );

  assign slot_free = !res_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    h_nxt     = h_r;
    mul_start = 1'b0;
    mul_a     = '0;
    q_pop     = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      mh64_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.first) begin
            mul_start = 1'b1;
            mul_a     = {32'd0, q_cmd.length};
            state_nxt = mh64_pkg::ST_INIT;
          end else begin
            state_nxt = mh64_pkg::ST_DISPATCH;
          end
        end
      end
      mh64_pkg::ST_INIT: begin
        if (mul_stat.done) begin
          h_nxt     = seed_r ^ mul_p;
          state_nxt = mh64_pkg::ST_DISPATCH;
        end
      end
      mh64_pkg::ST_DISPATCH: begin
        case (cmd_r.op)
          mh64_pkg::OP_BLOCK: begin
            mul_start = 1'b1;
            mul_a     = cmd_r.data;
            state_nxt = mh64_pkg::ST_K1;
          end
          mh64_pkg::OP_PARTIAL: begin
            mul_start = 1'b1;
            mul_a     = h_r ^ cmd_r.data;
            state_nxt = mh64_pkg::ST_H;
          end
          default: begin
            state_nxt = cmd_r.last ? mh64_pkg::ST_FINAL : mh64_pkg::ST_IDLE;
          end
        endcase
      end
      mh64_pkg::ST_K1: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mh64_pkg::shift_mix(mul_p);
          state_nxt = mh64_pkg::ST_K2;
        end
      end
      mh64_pkg::ST_K2: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = h_r ^ mul_p;
          state_nxt = mh64_pkg::ST_H;
        end
      end
      mh64_pkg::ST_H: begin
        if (mul_stat.done) begin
          h_nxt     = mul_p;
          state_nxt = cmd_r.last ? mh64_pkg::ST_FINAL : mh64_pkg::ST_IDLE;
        end
      end
      mh64_pkg::ST_FINAL: begin
        mul_start = 1'b1;
        mul_a     = mh64_pkg::shift_mix(h_r);
        state_nxt = mh64_pkg::ST_FIN;
      end
      mh64_pkg::ST_FIN: begin
        if (!mul_stat.busy && !mul_stat.done && slot_free) begin
          res_load  = 1'b1;
          state_nxt = mh64_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mh64_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r;
    if (res_load) begin
      res_nxt       = mh64_pkg::shift_mix(mul_p);
      res_valid_nxt = 1'b1;
    end else if (out_pop) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mh64_pkg::ST_IDLE;
      h_r         <= '0;
      seed_r      <= mh64_pkg::SEED_RESET;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
  end

  assign out_empty      = !res_valid_r;
  assign out_hash_value = res_r;

`ifndef NO_ASSERTIONS
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while still busy");
  a_pop_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == mh64_pkg::ST_IDLE && !q_empty))
    else $error("command taken outside the idle state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_valid_r) |-> out_pop)
    else $error("result register overwritten before its transfer");
`endif

endmodule

### rtl/core/murmur64a_hash64_unit.sv
// Top level of the streaming MurmurHash64A unit: front end, command queue and
// hash sequencer. Depends on mh64_pkg, mh64_front, mh64_cmd_queue, mh64_back.
//
//   Channel   Handshake        Payload
//   input     in_push/in_full  in_data_word, in_word_bytes, in_first_word,
//                              in_last_word, in_message_length
//   result    out_empty/out_pop out_hash_value
//   config    cfg_wr_en        cfg_wr_data (seed)
//
// Every 64-bit product goes through one 32x32 multiplier in three steps.
// A middle word takes three products; a first word adds one product for
// seeding, a last word adds one for finalization and then loads the result.
// A two-entry command queue takes words while the sequencer works, and the
// sequencer keeps going while one finished hash waits in the result register.
// Reset is synchronous; it empties both queues and reloads the default seed.
module murmur64a_hash64_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [31:0] in_message_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_hash_value
);

  mh64_pkg::cmd_t front_cmd;
  mh64_pkg::cmd_t head_cmd;
  logic           q_push, q_pop, q_full, q_empty;

  mh64_front u_front (
    .in_push        (in_push),
    .q_full         (q_full),
    .data_word      (in_data_word),
    .word_bytes     (in_word_bytes),
    .first_word     (in_first_word),
    .last_word      (in_last_word),
    .message_length (in_message_length),
    .q_push         (q_push),
    .q_cmd          (front_cmd)
  );

  mh64_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  mh64_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_cmd          (head_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_hash_value (out_hash_value)
  );

  assign in_full = q_full;

endmodule

### verif/murmur64a_hash64_unit_checker.sv
// Checker for the MurmurHash64A unit: follows seed writes and input transfers,
// predicts each finished hash and compares it with the result channel.
// Depends on mh64_pkg for the hash constants and the reset seed.
`timescale 1ns / 100ps

module murmur64a_hash64_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [31:0] in_message_length,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [63:0] out_hash_value,
  output int          fail_count,
  output int          pending_count
);

  logic [63:0] seed_reg;
  logic [63:0] running_state;
  logic [63:0] pending_hashes[$];
  int          reported;

  function automatic logic [63:0] scramble_word(input logic [63:0] k);
    logic [63:0] t;
    t = k * mh64_pkg::MUL_CONST;
    t = t ^ (t >> mh64_pkg::SHIFT_BITS);
    t = t * mh64_pkg::MUL_CONST;
    return t;
  endfunction

  function automatic logic [63:0] finalize_hash(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> mh64_pkg::SHIFT_BITS);
    t = t * mh64_pkg::MUL_CONST;
    t = t ^ (t >> mh64_pkg::SHIFT_BITS);
    return t;
  endfunction

  function automatic logic [63:0] absorb_word(
    input logic [63:0] prev,
    input logic [63:0] seed,
    input logic [63:0] data,
    input logic [3:0]  nbytes,
    input logic        first,
    input logic        last,
    input logic [31:0] len
  );
    logic [63:0] h;
    logic [63:0] mask;
    int          nb;
    h  = first ? (seed ^ ({32'b0, len} * mh64_pkg::MUL_CONST)) : prev;
    nb = int'(nbytes);
    if (!last || nb >= 8) begin
      h = h ^ scramble_word(data);
      h = h * mh64_pkg::MUL_CONST;
    end else if (nb != 0) begin
      mask = {64{1'b1}} >> (64 - 8 * nb);
      h    = h ^ (data & mask);
      h    = h * mh64_pkg::MUL_CONST;
    end
    return h;
  endfunction

  task automatic report_error(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    fail_count++;
    if (reported < 10) begin
      reported++;
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    reported      = 0;
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      seed_reg      = mh64_pkg::SEED_RESET;
      running_state = '0;
      pending_hashes.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_hashes.size() == 0) begin
          report_error("unexpected hash transfer", 'x, out_hash_value);
        end else begin
          want = pending_hashes.pop_front();
          if (out_hash_value !== want) begin
            report_error("hash_value mismatch", want, out_hash_value);
          end
        end
      end
      if (cfg_wr_en) begin
        seed_reg = cfg_wr_data;
      end
      if (in_push && !in_full) begin
        running_state = absorb_word(running_state, seed_reg, in_data_word, in_word_bytes,
                                    in_first_word, in_last_word, in_message_length);
        if (in_last_word) begin
          pending_hashes.push_back(finalize_hash(running_state));
        end
      end
    end
    pending_count = pending_hashes.size();
  end

endmodule

### verif/murmur64a_hash64_unit_tb.sv
// Testbench top for the MurmurHash64A unit: drives seed writes and word streams
// with varying idle and stall patterns and reports the checker's verdict.
// Depends on murmur64a_hash64_unit, murmur64a_hash64_unit_checker and mh64_pkg.
`timescale 1ns / 100ps

module murmur64a_hash64_unit_tb;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        cfg_wr_en         = 1'b0;
  logic [63:0] cfg_wr_data       = '0;
  logic        in_push           = 1'b0;
  logic        in_full;
  logic [63:0] in_data_word      = '0;
  logic [3:0]  in_word_bytes     = '0;
  logic        in_first_word     = 1'b0;
  logic        in_last_word      = 1'b0;
  logic [31:0] in_message_length = '0;
  logic        out_empty;
  logic        out_pop           = 1'b0;
  logic [63:0] out_hash_value;

  int fail_count;
  int pending_count;
  int words_sent = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;

  murmur64a_hash64_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_word      (in_data_word),
    .in_word_bytes     (in_word_bytes),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_hash_value    (out_hash_value)
  );

  murmur64a_hash64_unit_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_word      (in_data_word),
    .in_word_bytes     (in_word_bytes),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_hash_value    (out_hash_value),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_pop = ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Called and returning at a falling edge; push stays high after the transfer.
  task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic first, input logic last,
                           input logic [31:0] len);
    while ($urandom_range(99) < idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push           = 1'b1;
    in_data_word      = data;
    in_word_bytes     = nbytes;
    in_first_word     = first;
    in_last_word      = last;
    in_message_length = len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int nbytes, input logic [31:0] len_field,
                              input bit drop_tail);
    int         nwords;
    int         rem;
    logic       last;
    logic [3:0] wb;
    if (nbytes == 0) begin
      send_word(rand64(), 4'd0, 1'b1, 1'b1, len_field);
    end else begin
      nwords = (nbytes + 7) / 8;
      rem    = nbytes % 8;
      if (drop_tail && nwords > 1) nwords--;
      for (int i = 0; i < nwords; i++) begin
        last = (i == nwords - 1) && !drop_tail;
        if (!last) begin
          wb = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'd8;
        end else if (rem == 0) begin
          wb = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 8)) : 4'd8;
        end else begin
          wb = 4'(rem);
        end
        send_word(rand64(), wb, i == 0, last, len_field);
      end
    end
  endtask

  // The seed may only change while the unit holds no unfinished work.
  task automatic write_seed(input logic [63:0] value);
    in_push = 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_random(input int target);
    int          roll;
    int          nb;
    logic [31:0] len_field;
    while (words_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom);
      end else begin
        nb        = ($urandom_range(9) == 0) ? $urandom_range(256) : $urandom_range(40);
        len_field = ($urandom_range(6) == 0) ? $urandom : 32'(nb);
        send_message(nb, len_field, roll < 13);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the reset seed.
    send_word(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b1, 32'd0);
    send_word(rand64(), 4'd0, 1'b1, 1'b1, 32'd0);
    send_word({64{1'b1}}, 4'd0, 1'b1, 1'b1, 32'hffff_ffff);
    send_word(64'd0, 4'd8, 1'b1, 1'b1, 32'd8);
    send_word({64{1'b1}}, 4'd8, 1'b1, 1'b1, 32'd8);
    send_word({64{1'b1}}, 4'd15, 1'b1, 1'b1, 32'd8);
    send_word({64{1'b1}}, 4'd7, 1'b1, 1'b1, 32'd7);
    send_word({64{1'b1}}, 4'd1, 1'b1, 1'b1, 32'd1);
    send_word(rand64(), 4'd3, 1'b1, 1'b0, 32'd13);
    send_word({64{1'b1}}, 4'd5, 1'b0, 1'b1, 32'd13);
    send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd8);
    send_word(rand64(), 4'd0, 1'b0, 1'b1, 32'd8);
    send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd24);
    send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd16);
    send_word(rand64(), 4'd0, 1'b0, 1'b1, 32'd16);
    send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'h8000_0001);
    send_word(rand64(), 4'd2, 1'b0, 1'b1, 32'h8000_0001);
    send_word(rand64(), 4'd8, 1'b0, 1'b0, 32'd0);
    send_word(rand64(), 4'd4, 1'b0, 1'b1, 32'd0);

    write_seed('0);
    run_random(430);

    write_seed({64{1'b1}});
    idle_pct = 56;
    run_random(840);

    write_seed(rand64());
    idle_pct  = 0;
    stall_pct = 56;
    run_random(1250);

    write_seed(rand64());
    idle_pct  = 19;
    stall_pct = 19;
    run_random(1670);

    in_push   = 1'b0;
    stall_pct = 0;
    wait (pending_count == 0);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
